### design/strided_conv3x3_threshold_defines.svh
// Assertion macros shared by the checker of the strided 3x3 convolution block.
// No dependencies; taken in by `include where assertions are written.
`ifndef STRIDED_CONV3X3_THRESHOLD_DEFINES_SVH
`define STRIDED_CONV3X3_THRESHOLD_DEFINES_SVH

// ante in one cycle implies cons in the next, ignored while reset is high
`define SC3T_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// cons must hold in the cycle after any cycle with reset high
`define SC3T_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

### design/sc3t_pkg.sv
// Shared constants, types and register codes of the strided 3x3 convolution block.
// No dependencies; the design files refer to it by scoped names, the bench imports it.
`default_nettype none

package sc3t_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int KERNEL_SIZE = 3;
   localparam int COEFF_BITS  = 16;
   localparam int COEFF_SLOT  = 16;

   localparam int PIX_W     = 8;
   localparam int POS_W     = 10;
   localparam int SIZE_W    = 11;
   localparam int STRIDE_W  = 8;
   localparam int THR_W     = 28;
   localparam int ROW_REG_W = KERNEL_SIZE * COEFF_SLOT;

   localparam int MAX_ROWS  = 1 << POS_W;
   localparam int W_CAP     = (MAX_WIDTH < (1 << POS_W)) ? MAX_WIDTH : (1 << POS_W);
   localparam int LINE_AW   = $clog2(MAX_WIDTH);
   localparam int LINE_DW   = 2 * PIX_W;

   localparam int PHASE_W   = STRIDE_W;
   localparam int REM_W     = STRIDE_W + 1;
   localparam int REM_CNT_W = $clog2(POS_W);

   localparam int PROD_W    = PIX_W + 1 + COEFF_BITS;
   localparam int ROWSUM_W  = PROD_W + 2;
   localparam int SUM_W     = PROD_W + 4;

   localparam int CSR_AW    = 6;
   localparam int CSR_DW    = 64;
   localparam int REG_IDX_W = CSR_AW - 3;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_STRIDE       = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COEFF_TOP    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COEFF_MIDDLE = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_COEFF_BOTTOM = 3'd6;

   localparam logic [SIZE_W-1:0]   RESET_WIDTH     = 11'd640;
   localparam logic [SIZE_W-1:0]   RESET_HEIGHT    = 11'd480;
   localparam logic [STRIDE_W-1:0] RESET_STRIDE    = 8'd4;
   localparam logic [THR_W-1:0]    RESET_THRESHOLD = 28'd14592;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_REMAP
   } state_type;

   typedef struct packed {
      logic [SIZE_W-1:0]                        image_width;
      logic [SIZE_W-1:0]                        image_height;
      logic [STRIDE_W-1:0]                      stride;
      logic [THR_W-1:0]                         threshold;
      logic [KERNEL_SIZE-1:0][ROW_REG_W-1:0]    coeff_rows;
   } cfg_type;

   typedef struct packed {
      logic             on_grid;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             frame_end;
   } meta_type;

   // [row][column], row 0 oldest line, column 0 oldest pixel
   typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] window_type;

endpackage

`default_nettype wire

### design/sc3t_csr.sv
// Configuration register file with its APB-style access port.
// Depends on sc3t_pkg for the register codes, reset values and cfg_type.
`default_nettype none

module sc3t_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [sc3t_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [sc3t_pkg::CSR_DW-1:0]  pwdata,
   output logic      [sc3t_pkg::CSR_DW-1:0]  prdata,
   output logic                              pready,
   output sc3t_pkg::cfg_type                 cfg,
   output logic                              stride_write
);

   logic [sc3t_pkg::REG_IDX_W-1:0] idx;
   logic                           wr_en;
   sc3t_pkg::cfg_type              cfg_ff;

   assign idx          = paddr[sc3t_pkg::CSR_AW-1 -: sc3t_pkg::REG_IDX_W];
   assign pready       = 1'b1;
   assign wr_en        = psel & penable & pwrite & pready;
   assign stride_write = wr_en && (idx == sc3t_pkg::REG_STRIDE);
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= sc3t_pkg::RESET_WIDTH;
         cfg_ff.image_height <= sc3t_pkg::RESET_HEIGHT;
         cfg_ff.stride       <= sc3t_pkg::RESET_STRIDE;
         cfg_ff.threshold    <= sc3t_pkg::RESET_THRESHOLD;
         cfg_ff.coeff_rows   <= '0;
      end else if (wr_en) begin
         unique case (idx)
            sc3t_pkg::REG_IMAGE_WIDTH:
               cfg_ff.image_width <= pwdata[sc3t_pkg::SIZE_W-1:0];
            sc3t_pkg::REG_IMAGE_HEIGHT:
               cfg_ff.image_height <= pwdata[sc3t_pkg::SIZE_W-1:0];
            sc3t_pkg::REG_STRIDE:
               cfg_ff.stride <= pwdata[sc3t_pkg::STRIDE_W-1:0];
            sc3t_pkg::REG_THRESHOLD:
               cfg_ff.threshold <= pwdata[sc3t_pkg::THR_W-1:0];
            sc3t_pkg::REG_COEFF_TOP:
               cfg_ff.coeff_rows[0] <= pwdata[sc3t_pkg::ROW_REG_W-1:0];
            sc3t_pkg::REG_COEFF_MIDDLE:
               cfg_ff.coeff_rows[1] <= pwdata[sc3t_pkg::ROW_REG_W-1:0];
            sc3t_pkg::REG_COEFF_BOTTOM:
               cfg_ff.coeff_rows[2] <= pwdata[sc3t_pkg::ROW_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         sc3t_pkg::REG_IMAGE_WIDTH:  prdata = sc3t_pkg::CSR_DW'(cfg_ff.image_width);
         sc3t_pkg::REG_IMAGE_HEIGHT: prdata = sc3t_pkg::CSR_DW'(cfg_ff.image_height);
         sc3t_pkg::REG_STRIDE:       prdata = sc3t_pkg::CSR_DW'(cfg_ff.stride);
         sc3t_pkg::REG_THRESHOLD:    prdata = sc3t_pkg::CSR_DW'(cfg_ff.threshold);
         sc3t_pkg::REG_COEFF_TOP:    prdata = sc3t_pkg::CSR_DW'(cfg_ff.coeff_rows[0]);
         sc3t_pkg::REG_COEFF_MIDDLE: prdata = sc3t_pkg::CSR_DW'(cfg_ff.coeff_rows[1]);
         sc3t_pkg::REG_COEFF_BOTTOM: prdata = sc3t_pkg::CSR_DW'(cfg_ff.coeff_rows[2]);
         default:                    prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

### design/sc3t_filter.sv
// Flipped 3x3 multiply-accumulate and threshold compare, three register stages deep,
// ending in the result register. Depends on sc3t_pkg for widths and types.
`default_nettype none

module sc3t_filter (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   output logic                                         in_ready,
   input  wire sc3t_pkg::window_type                    in_window,
   input  wire sc3t_pkg::meta_type                      in_meta,
   input  wire logic [sc3t_pkg::KERNEL_SIZE-1:0][sc3t_pkg::ROW_REG_W-1:0] coeff_rows,
   input  wire logic [sc3t_pkg::THR_W-1:0]              threshold,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic                                         rsp_moving,
   output logic      [sc3t_pkg::POS_W-1:0]              rsp_out_row,
   output logic      [sc3t_pkg::POS_W-1:0]              rsp_out_col,
   output logic                                         rsp_frame_end
);

   localparam int K = sc3t_pkg::KERNEL_SIZE;

   logic                                   p_valid_ff;
   logic                                   p_ready;
   logic signed [sc3t_pkg::PROD_W-1:0]     prod_ff [K][K];
   logic signed [sc3t_pkg::PROD_W-1:0]     prod_in [K][K];
   sc3t_pkg::meta_type                     p_meta_ff;

   logic                                   r_valid_ff;
   logic                                   r_ready;
   logic signed [sc3t_pkg::ROWSUM_W-1:0]   rowsum_ff [K];
   logic signed [sc3t_pkg::ROWSUM_W-1:0]   rowsum_in [K];
   sc3t_pkg::meta_type                     r_meta_ff;

   logic                                   o_valid_ff;
   logic                                   o_en;
   logic                                   moving_ff;
   logic                                   moving_in;
   sc3t_pkg::meta_type                     o_meta_ff;
   logic signed [sc3t_pkg::SUM_W-1:0]      sum;
   logic signed [sc3t_pkg::SUM_W-1:0]      thr_ext;

   function automatic logic signed [sc3t_pkg::COEFF_BITS-1:0] coeff_at(
      input logic [K-1:0][sc3t_pkg::ROW_REG_W-1:0] rows,
      input int                                  r,
      input int                                  n
   );
      logic [sc3t_pkg::ROW_REG_W-1:0] row;
      row = rows[r];
      return $signed(row[n*sc3t_pkg::COEFF_SLOT +: sc3t_pkg::COEFF_BITS]);
   endfunction

   assign o_en     = !o_valid_ff || !rsp_stall;
   assign r_ready  = !r_valid_ff || o_en;
   assign p_ready  = !p_valid_ff || r_ready;
   assign in_ready = p_ready;

   // mask flipped in both directions
   always_comb begin
      for (int m = 0; m < K; m++) begin
         for (int n = 0; n < K; n++) begin
            prod_in[m][n] = $signed({1'b0, in_window[m][n]})
                          * coeff_at(coeff_rows, K - 1 - m, K - 1 - n);
         end
      end
   end

   always_comb begin
      for (int m = 0; m < K; m++) begin
         rowsum_in[m] = sc3t_pkg::ROWSUM_W'(prod_ff[m][0])
                      + sc3t_pkg::ROWSUM_W'(prod_ff[m][1])
                      + sc3t_pkg::ROWSUM_W'(prod_ff[m][2]);
      end
   end

   always_comb begin
      sum = sc3t_pkg::SUM_W'(rowsum_ff[0]) + sc3t_pkg::SUM_W'(rowsum_ff[1])
          + sc3t_pkg::SUM_W'(rowsum_ff[2]);
      thr_ext = $signed({{(sc3t_pkg::SUM_W - sc3t_pkg::THR_W){threshold[sc3t_pkg::THR_W-1]}},
                         threshold});
      moving_in = r_meta_ff.on_grid && (sum >= thr_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (p_ready) begin
            p_valid_ff <= in_valid;
         end
         if (r_ready) begin
            r_valid_ff <= p_valid_ff;
         end
         if (o_en) begin
            o_valid_ff <= r_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && in_valid) begin
         prod_ff   <= prod_in;
         p_meta_ff <= in_meta;
      end
      if (r_ready && p_valid_ff) begin
         rowsum_ff <= rowsum_in;
         r_meta_ff <= p_meta_ff;
      end
      if (o_en && r_valid_ff) begin
         moving_ff <= moving_in;
         o_meta_ff <= r_meta_ff;
      end
   end

   assign rsp_valid     = o_valid_ff;
   assign rsp_moving    = moving_ff;
   assign rsp_out_row   = o_meta_ff.out_row;
   assign rsp_out_col   = o_meta_ff.out_col;
   assign rsp_frame_end = o_meta_ff.frame_end;

endmodule

`default_nettype wire

### design/strided_conv3x3_threshold.sv
// A result is offered on rsp once the pixel that completes its window has passed the stages below.
// Throughput: one pixel per cycle while req_stall is low; pixel stage, products, row sums and result register.
// Reset: synchronous; the two-line store is then cleared entry by entry with req_stall high.
// A stride write holds req_stall high while the grid phases are recomputed.
// Top level: position tracking, line store, 3x3 window; needs sc3t_pkg, sc3t_csr, sc3t_filter.
`default_nettype none

module strided_conv3x3_threshold (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [sc3t_pkg::PIX_W-1:0]         req_pixel,
   input  wire logic                               req_frame_start,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_moving,
   output logic      [sc3t_pkg::POS_W-1:0]         rsp_out_row,
   output logic      [sc3t_pkg::POS_W-1:0]         rsp_out_col,
   output logic                                    rsp_frame_end,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [sc3t_pkg::CSR_AW-1:0]        csr_paddr,
   input  wire logic [sc3t_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic      [sc3t_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                                    csr_pready
);

   localparam int K = sc3t_pkg::KERNEL_SIZE;

   sc3t_pkg::cfg_type                   cfg;
   logic                                stride_write;

   logic [sc3t_pkg::SIZE_W-1:0]         eff_width;
   logic [sc3t_pkg::SIZE_W-1:0]         eff_height;

   sc3t_pkg::state_type                 state_ff, state_in;
   logic [sc3t_pkg::LINE_AW-1:0]        clr_addr_ff, clr_addr_in;
   logic [sc3t_pkg::REM_CNT_W-1:0]      rem_cnt_ff, rem_cnt_in;
   logic [sc3t_pkg::REM_W-1:0]          rem_col_ff, rem_col_in;
   logic [sc3t_pkg::REM_W-1:0]          rem_row_ff, rem_row_in;
   logic                                remap_done;

   logic [sc3t_pkg::POS_W-1:0]          row_pos_ff, row_pos_in;
   logic [sc3t_pkg::POS_W-1:0]          col_pos_ff, col_pos_in;
   logic [sc3t_pkg::PHASE_W-1:0]        row_phase_ff, row_phase_in;
   logic [sc3t_pkg::PHASE_W-1:0]        col_phase_ff, col_phase_in;

   logic [sc3t_pkg::POS_W-1:0]          cur_row, cur_col;
   logic [sc3t_pkg::PHASE_W-1:0]        cur_row_phase, cur_col_phase;
   logic [sc3t_pkg::PHASE_W-1:0]        grid_phase;
   logic [sc3t_pkg::SIZE_W-1:0]         col_next, row_next;
   logic                                in_range, emit;
   sc3t_pkg::meta_type                  meta_in;

   logic                                req_accept;
   logic                                s1_valid_ff;
   logic                                s1_in_range_ff;
   logic                                s1_emit_ff;
   logic [sc3t_pkg::PIX_W-1:0]          s1_pixel_ff;
   logic [sc3t_pkg::LINE_AW-1:0]        s1_addr_ff;
   sc3t_pkg::meta_type                  s1_meta_ff;
   logic                                s1_go;

   logic [sc3t_pkg::LINE_DW-1:0]        line_mem [sc3t_pkg::MAX_WIDTH];
   logic [sc3t_pkg::LINE_DW-1:0]        mem_rd_ff;
   logic                                byp_ff;
   logic [sc3t_pkg::LINE_DW-1:0]        byp_data_ff;
   logic [sc3t_pkg::LINE_DW-1:0]        s1_line;
   logic [sc3t_pkg::PIX_W-1:0]          s1_top, s1_mid;
   logic                                mem_wr_en;
   logic [sc3t_pkg::LINE_AW-1:0]        mem_wr_addr;
   logic [sc3t_pkg::LINE_DW-1:0]        mem_wr_data;
   logic [sc3t_pkg::LINE_AW-1:0]        rd_addr;

   sc3t_pkg::window_type                window_ff, window_in;
   logic                                filt_ready;

   function automatic logic [sc3t_pkg::REM_W-1:0] rem_step(
      input logic [sc3t_pkg::REM_W-1:0]    r,
      input logic                          b,
      input logic [sc3t_pkg::STRIDE_W-1:0] s
   );
      logic [sc3t_pkg::REM_W-1:0] t;
      t = {r[sc3t_pkg::REM_W-2:0], b};
      if (t >= {1'b0, s}) begin
         t = t - {1'b0, s};
      end
      return t;
   endfunction

   function automatic logic [sc3t_pkg::PHASE_W-1:0] phase_inc(
      input logic [sc3t_pkg::PHASE_W-1:0]  p,
      input logic [sc3t_pkg::STRIDE_W-1:0] s
   );
      logic [sc3t_pkg::PHASE_W:0] t;
      t = {1'b0, p} + 1'b1;
      if (t == {1'b0, s}) begin
         t = '0;
      end
      return t[sc3t_pkg::PHASE_W-1:0];
   endfunction

   sc3t_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .pready       (csr_pready),
      .cfg          (cfg),
      .stride_write (stride_write)
   );

   always_comb begin
      eff_width = cfg.image_width;
      if (eff_width > sc3t_pkg::SIZE_W'(sc3t_pkg::W_CAP)) begin
         eff_width = sc3t_pkg::SIZE_W'(sc3t_pkg::W_CAP);
      end
      if (eff_width == '0) begin
         eff_width = sc3t_pkg::SIZE_W'(1);
      end
      eff_height = cfg.image_height;
      if (eff_height > sc3t_pkg::SIZE_W'(sc3t_pkg::MAX_ROWS)) begin
         eff_height = sc3t_pkg::SIZE_W'(sc3t_pkg::MAX_ROWS);
      end
      if (eff_height == '0) begin
         eff_height = sc3t_pkg::SIZE_W'(1);
      end
   end

   // clear pass, then run; a stride write recomputes position modulo stride bit-serially
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sc3t_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         rem_cnt_ff  <= '0;
         rem_col_ff  <= '0;
         rem_row_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         rem_cnt_ff  <= rem_cnt_in;
         rem_col_ff  <= rem_col_in;
         rem_row_ff  <= rem_row_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      rem_cnt_in  = rem_cnt_ff;
      rem_col_in  = rem_col_ff;
      rem_row_in  = rem_row_ff;
      remap_done  = 1'b0;
      unique case (state_ff)
         sc3t_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = stride_write ? sc3t_pkg::ST_REMAP : sc3t_pkg::ST_RUN;
            end
         end
         sc3t_pkg::ST_RUN: begin
            if (stride_write) begin
               state_in = sc3t_pkg::ST_REMAP;
            end
         end
         sc3t_pkg::ST_REMAP: begin
            rem_col_in = rem_step(rem_col_ff, col_pos_ff[rem_cnt_ff], cfg.stride);
            rem_row_in = rem_step(rem_row_ff, row_pos_ff[rem_cnt_ff], cfg.stride);
            rem_cnt_in = rem_cnt_ff - 1'b1;
            if (rem_cnt_ff == '0) begin
               state_in   = sc3t_pkg::ST_RUN;
               remap_done = 1'b1;
            end
         end
         default: begin
            state_in = sc3t_pkg::ST_CLEAR;
         end
      endcase
      if (stride_write) begin
         rem_cnt_in = sc3t_pkg::REM_CNT_W'(sc3t_pkg::POS_W - 1);
         rem_col_in = '0;
         rem_row_in = '0;
         if (state_ff == sc3t_pkg::ST_REMAP) begin
            state_in = sc3t_pkg::ST_REMAP;
         end
      end
   end

   assign s1_go      = s1_valid_ff && (!s1_emit_ff || filt_ready);
   assign req_stall  = (state_ff != sc3t_pkg::ST_RUN) || (s1_valid_ff && !s1_go);
   assign req_accept = req_valid && !req_stall;

   // position of this pixel and of the next one
   always_comb begin
      cur_row       = req_frame_start ? '0 : row_pos_ff;
      cur_col       = req_frame_start ? '0 : col_pos_ff;
      cur_row_phase = req_frame_start ? '0 : row_phase_ff;
      cur_col_phase = req_frame_start ? '0 : col_phase_ff;

      in_range = ({1'b0, cur_col} < eff_width) && ({1'b0, cur_row} < eff_height);
      emit     = in_range && (cur_row >= sc3t_pkg::POS_W'(2))
                          && (cur_col >= sc3t_pkg::POS_W'(2));

      grid_phase = (cfg.stride == sc3t_pkg::STRIDE_W'(1)) ? '0 : sc3t_pkg::PHASE_W'(1);
      meta_in.on_grid   = (cfg.stride != '0)
                        && (cur_row > sc3t_pkg::POS_W'(cfg.stride))
                        && (cur_col > sc3t_pkg::POS_W'({cfg.stride, 1'b0}))
                        && (cur_row_phase == grid_phase)
                        && (cur_col_phase == grid_phase);
      meta_in.out_row   = cur_row - sc3t_pkg::POS_W'(2);
      meta_in.out_col   = cur_col - sc3t_pkg::POS_W'(2);
      meta_in.frame_end = ({1'b0, cur_row} == eff_height - 1'b1)
                        && ({1'b0, cur_col} == eff_width - 1'b1);

      col_next = {1'b0, cur_col} + 1'b1;
      row_next = {1'b0, cur_row} + 1'b1;
      if (col_next >= eff_width) begin
         col_pos_in   = '0;
         col_phase_in = '0;
         if (row_next >= eff_height) begin
            row_pos_in   = '0;
            row_phase_in = '0;
         end else begin
            row_pos_in   = row_next[sc3t_pkg::POS_W-1:0];
            row_phase_in = phase_inc(cur_row_phase, cfg.stride);
         end
      end else begin
         col_pos_in   = col_next[sc3t_pkg::POS_W-1:0];
         col_phase_in = phase_inc(cur_col_phase, cfg.stride);
         row_pos_in   = cur_row;
         row_phase_in = cur_row_phase;
      end
      if ({1'b0, row_pos_in} >= eff_height) begin
         row_pos_in   = '0;
         row_phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         row_phase_ff <= '0;
         col_phase_ff <= '0;
      end else if (req_accept) begin
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         row_phase_ff <= row_phase_in;
         col_phase_ff <= col_phase_in;
      end else if (remap_done) begin
         if (cfg.stride == '0) begin
            row_phase_ff <= '0;
            col_phase_ff <= '0;
         end else begin
            row_phase_ff <= rem_row_in[sc3t_pkg::PHASE_W-1:0];
            col_phase_ff <= rem_col_in[sc3t_pkg::PHASE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_in_range_ff <= in_range;
         s1_emit_ff     <= emit;
         s1_pixel_ff    <= req_pixel;
         s1_addr_ff     <= rd_addr;
         s1_meta_ff     <= meta_in;
      end
   end

   // line store entry: {upper line, lower line} at one column
   assign rd_addr     = sc3t_pkg::LINE_AW'(cur_col);
   assign mem_wr_en   = (state_ff == sc3t_pkg::ST_CLEAR) || (s1_go && s1_in_range_ff);
   assign mem_wr_addr = (state_ff == sc3t_pkg::ST_CLEAR) ? clr_addr_ff : s1_addr_ff;
   assign mem_wr_data = (state_ff == sc3t_pkg::ST_CLEAR) ? '0 : {s1_mid, s1_pixel_ff};

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         line_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (req_accept) begin
         mem_rd_ff <= line_mem[rd_addr];
      end
   end

   // forward a write that lands on the address read in the same cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         byp_ff      <= mem_wr_en && (mem_wr_addr == rd_addr);
         byp_data_ff <= mem_wr_data;
      end
   end

   assign s1_line = byp_ff ? byp_data_ff : mem_rd_ff;
   assign s1_top  = s1_line[sc3t_pkg::LINE_DW-1 -: sc3t_pkg::PIX_W];
   assign s1_mid  = s1_line[sc3t_pkg::PIX_W-1:0];

   always_comb begin
      window_in = window_ff;
      for (int m = 0; m < K; m++) begin
         for (int n = 0; n < K - 1; n++) begin
            window_in[m][n] = window_ff[m][n+1];
         end
      end
      window_in[0][K-1] = s1_top;
      window_in[1][K-1] = s1_mid;
      window_in[2][K-1] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_in_range_ff) begin
         window_ff <= window_in;
      end
   end

   sc3t_filter u_filter (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s1_valid_ff && s1_emit_ff),
      .in_ready      (filt_ready),
      .in_window     (window_in),
      .in_meta       (s1_meta_ff),
      .coeff_rows    (cfg.coeff_rows),
      .threshold     (cfg.threshold),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_moving    (rsp_moving),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

### design/sc3t_checker.sv
// Port-level checker for the strided 3x3 convolution block, bound to the top level.
// Depends on sc3t_pkg and the assertion macros in strided_conv3x3_threshold_defines.svh.
`default_nettype none
`include "strided_conv3x3_threshold_defines.svh"

module sc3t_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_moving,
   input wire logic [sc3t_pkg::POS_W-1:0]    rsp_out_row,
   input wire logic [sc3t_pkg::POS_W-1:0]    rsp_out_col,
   input wire logic                          rsp_frame_end,
   input wire logic                          csr_psel,
   input wire logic                          csr_penable,
   input wire logic                          csr_pwrite,
   input wire logic [sc3t_pkg::CSR_AW-1:0]   csr_paddr
);

   `SC3T_ASSERT_AFTER_RESET(a_reset_quiet, clock, reset, req_stall && !rsp_valid, "no stall or stray result after reset")

   `SC3T_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_moving) && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_end), "stalled result transfer changed")

   `SC3T_ASSERT_NEXT(a_stride_stall, clock, reset, csr_psel && csr_penable && csr_pwrite && csr_paddr[sc3t_pkg::CSR_AW-1 -: sc3t_pkg::REG_IDX_W] == sc3t_pkg::REG_STRIDE, req_stall, "input not held after stride write")

endmodule

bind strided_conv3x3_threshold sc3t_checker u_sc3t_checker (.*);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for strided_conv3x3_threshold: directed and random pixels, binary map tracker.
// Depends on sc3t_pkg and the block's RTL; drives clock, reset, pixel, result and register ports.
`default_nettype none

module tb_top;
   import sc3t_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PIXELS = 1700;

   class binary_map_tracker;
      typedef struct {
         logic             moving;
         logic [POS_W-1:0] out_row;
         logic [POS_W-1:0] out_col;
         logic             frame_end;
      } map_pixel;

      logic [SIZE_W-1:0]    image_width;
      logic [SIZE_W-1:0]    image_height;
      logic [STRIDE_W-1:0]  stride;
      logic [THR_W-1:0]     threshold;
      logic [ROW_REG_W-1:0] coeff_rows [KERNEL_SIZE];
      logic [PIX_W-1:0]     line_mem [2*MAX_WIDTH];
      logic [PIX_W-1:0]     win [KERNEL_SIZE][KERNEL_SIZE];
      int unsigned          row_pos;
      int unsigned          col_pos;
      map_pixel             awaited [$];
      int unsigned          mismatch_count;

      function new();
         image_width    = RESET_WIDTH;
         image_height   = RESET_HEIGHT;
         stride         = RESET_STRIDE;
         threshold      = RESET_THRESHOLD;
         foreach (coeff_rows[r]) coeff_rows[r] = '0;
         foreach (line_mem[k]) line_mem[k] = '0;
         foreach (win[r, c]) win[r][c] = '0;
         row_pos        = 0;
         col_pos        = 0;
         mismatch_count = 0;
      endfunction

      function void write_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_IMAGE_WIDTH:  image_width   = value[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: image_height  = value[SIZE_W-1:0];
            REG_STRIDE:       stride        = value[STRIDE_W-1:0];
            REG_THRESHOLD:    threshold     = value[THR_W-1:0];
            REG_COEFF_TOP:    coeff_rows[0] = value[ROW_REG_W-1:0];
            REG_COEFF_MIDDLE: coeff_rows[1] = value[ROW_REG_W-1:0];
            REG_COEFF_BOTTOM: coeff_rows[2] = value[ROW_REG_W-1:0];
            default: ;
         endcase
      endfunction

      function longint tap(int unsigned r, int unsigned n);
         logic signed [COEFF_BITS-1:0] c;
         c = coeff_rows[r][COEFF_SLOT*n +: COEFF_BITS];
         return longint'(c);
      endfunction

      function void take_pixel(logic [PIX_W-1:0] pixel, logic frame_start);
         int unsigned             w, h, x, y, xi, i, j, s, r, m, n;
         logic [PIX_W-1:0]        top, mid;
         logic signed [THR_W-1:0] level;
         longint                  sum;
         map_pixel                res;
         w = image_width;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         if (w < 1) w = 1;
         h = image_height;
         if (h > MAX_ROWS) h = MAX_ROWS;
         if (h < 1) h = 1;
         if (frame_start) begin
            row_pos = 0;
            col_pos = 0;
         end
         y = row_pos;
         x = col_pos;
         if (x < w && y < h) begin
            xi  = x % MAX_WIDTH;
            top = line_mem[xi];
            mid = line_mem[MAX_WIDTH + xi];
            line_mem[xi] = mid;
            line_mem[MAX_WIDTH + xi] = pixel;
            for (r = 0; r < KERNEL_SIZE; r++) begin
               win[r][0] = win[r][1];
               win[r][1] = win[r][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = pixel;
            if (y >= 2 && x >= 2) begin
               i = y - 1;
               j = x - 1;
               s = stride;
               res.moving = 1'b0;
               if (s != 0 && i >= s && i % s == 0 && j >= 2*s && j % s == 0) begin
                  sum = 0;
                  for (m = 0; m < KERNEL_SIZE; m++)
                     for (n = 0; n < KERNEL_SIZE; n++)
                        sum += longint'(win[m][n]) * tap(2 - m, 2 - n);
                  level = threshold;
                  res.moving = (sum >= longint'(level));
               end
               res.out_row   = POS_W'(y - 2);
               res.out_col   = POS_W'(x - 2);
               res.frame_end = (y == h - 1 && x == w - 1);
               awaited.push_back(res);
            end
         end
         x++;
         if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
         end
         if (y >= h) y = 0;
         row_pos = y & 32'h3FF;
         col_pos = x & 32'h3FF;
      endfunction

      function void flag_mismatch(string text);
         mismatch_count++;
         if (mismatch_count <= 10) $display("%s", text);
      endfunction

      function void match_output(logic moving, logic [POS_W-1:0] out_row,
                                 logic [POS_W-1:0] out_col, logic frame_end);
         map_pixel want;
         if (awaited.size() == 0) begin
            flag_mismatch($sformatf("unexpected transfer: row %0d col %0d moving %0b frame_end %0b",
                                    out_row, out_col, moving, frame_end));
            return;
         end
         want = awaited.pop_front();
         if (want.moving !== moving || want.out_row !== out_row ||
             want.out_col !== out_col || want.frame_end !== frame_end)
            flag_mismatch($sformatf({"mismatch: expected row %0d col %0d moving %0b frame_end %0b,",
                                     " got row %0d col %0d moving %0b frame_end %0b"},
                                    want.out_row, want.out_col, want.moving, want.frame_end,
                                    out_row, out_col, moving, frame_end));
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [PIX_W-1:0]    req_pixel       = '0;
   logic                req_frame_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic                rsp_moving;
   logic [POS_W-1:0]    rsp_out_row;
   logic [POS_W-1:0]    rsp_out_col;
   logic                rsp_frame_end;
   logic                csr_psel        = 1'b0;
   logic                csr_penable     = 1'b0;
   logic                csr_pwrite      = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr       = '0;
   logic [CSR_DW-1:0]   csr_pwdata      = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   int unsigned         send_idle_pct   = 36;
   int unsigned         recv_stall_pct  = 72;
   int unsigned         cycle_count     = 0;
   binary_map_tracker   tracker         = new();

   strided_conv3x3_threshold uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_moving      (rsp_moving),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_frame_end   (rsp_frame_end),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) tracker.take_pixel(req_pixel, req_frame_start);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_output(rsp_moving, rsp_out_row, rsp_out_col, rsp_frame_end);
   end

   task automatic write_csr(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DW-1:0] value);
      while (req_stall) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.write_register(idx, value);
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pixel, input logic frame_start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_pixel <= PIX_W'($urandom_range(255));
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= pixel;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic stream_pixels(input int unsigned frame_len, input int unsigned count,
                                input bit continue_frame, input int unsigned noise_pct);
      int unsigned      k;
      logic             fs;
      logic [PIX_W-1:0] pix;
      for (k = 0; k < count; k++) begin
         fs = (frame_len != 0) && (k % frame_len == 0) && !(k == 0 && continue_frame);
         if ($urandom_range(99) < noise_pct) fs = ~fs;
         case ($urandom_range(9))
            0:       pix = '0;
            1:       pix = '1;
            default: pix = PIX_W'($urandom_range(255));
         endcase
         send_pixel(pix, fs);
      end
   endtask

   function automatic logic [THR_W-1:0] level_near_zero();
      logic [THR_W-1:0] t;
      t = THR_W'($urandom_range(0, 32'h2000000));
      return t - THR_W'(32'h1000000);
   endfunction

   task automatic load_mask(input int unsigned write_pct);
      if ($urandom_range(99) < write_pct) write_csr(REG_COEFF_TOP, {$urandom, $urandom});
      if ($urandom_range(99) < write_pct) write_csr(REG_COEFF_MIDDLE, {$urandom, $urandom});
      if ($urandom_range(99) < write_pct) write_csr(REG_COEFF_BOTTOM, {$urandom, $urandom});
   endtask

   task automatic run_directed();
      int unsigned      k;
      logic [PIX_W-1:0] pix;
      @(posedge clock);
      write_csr(REG_IMAGE_WIDTH, 64'd5);
      write_csr(REG_IMAGE_HEIGHT, 64'd4);
      write_csr(REG_THRESHOLD, 64'd0);
      write_csr(REG_COEFF_TOP, {16'h0, 16'h0100, 16'h7FFF, 16'h8000});
      write_csr(REG_COEFF_MIDDLE, {16'h0, 16'hFF00, 16'h0080, 16'h0001});
      write_csr(REG_COEFF_BOTTOM, {16'h0, 16'h8000, 16'h0000, 16'h7FFF});
      write_csr(REG_STRIDE, 64'd1);
      // one 5x4 frame, then wrap into the next without frame_start
      for (k = 0; k < 25; k++) begin
         case (k % 3)
            0:       pix = '0;
            1:       pix = '1;
            default: pix = PIX_W'($urandom_range(255));
         endcase
         send_pixel(pix, k == 0);
      end
      settle();
   endtask

   task automatic run_random_phase(inout int unsigned sent);
      int unsigned     sel, pick, w, h, we, he, n;
      logic            odd_size;
      logic [STRIDE_W-1:0] st;
      logic [THR_W-1:0]    level;
      sel = $urandom_range(99);
      w   = $urandom_range(3, 12);
      h   = $urandom_range(3, 10);
      if (sel < 4) w = $urandom_range(0, 2);
      else if (sel < 8) h = $urandom_range(0, 2);
      else if (sel < 11) w = $urandom_range(1025, 2047);
      else if (sel < 14) h = $urandom_range(1025, 2047);
      odd_size = (sel < 14);
      we = (w > MAX_WIDTH) ? MAX_WIDTH : ((w < 1) ? 1 : w);
      he = (h > MAX_ROWS) ? MAX_ROWS : ((h < 1) ? 1 : h);
      write_csr(REG_IMAGE_WIDTH, 64'(w));
      write_csr(REG_IMAGE_HEIGHT, 64'(h));
      pick = $urandom_range(99);
      if (pick < 6) level = 28'h8000000;
      else if (pick < 12) level = 28'h7FFFFFF;
      else level = level_near_zero();
      if ($urandom_range(99) < 60) write_csr(REG_THRESHOLD, 64'(level));
      load_mask(50);
      pick = $urandom_range(99);
      if (pick < 8) st = '0;
      else if (pick < 14) st = '1;
      else if (pick < 22) st = STRIDE_W'($urandom_range(5, 254));
      else st = STRIDE_W'($urandom_range(1, 4));
      if ($urandom_range(99) < 60) write_csr(REG_STRIDE, 64'(st));
      if (odd_size) n = $urandom_range(10, 40);
      else n = $urandom_range(1, 2) * we * he + $urandom_range(0, we);
      stream_pixels(we * he, n, $urandom_range(99) < 25, odd_size ? 5 : 2);
      settle();
      if (!odd_size) sent += n;
   endtask

   task automatic run_large_frames();
      write_csr(REG_IMAGE_WIDTH, 64'd2047);
      write_csr(REG_IMAGE_HEIGHT, 64'd3);
      write_csr(REG_THRESHOLD, 64'(level_near_zero()));
      load_mask(100);
      write_csr(REG_STRIDE, 64'd1);
      stream_pixels(3 * MAX_WIDTH, 3 * MAX_WIDTH, 1'b0, 0);
      settle();
      write_csr(REG_IMAGE_WIDTH, 64'd3);
      write_csr(REG_IMAGE_HEIGHT, 64'd2047);
      write_csr(REG_STRIDE, 64'($urandom_range(1, 4)));
      stream_pixels(3 * MAX_ROWS, 3 * MAX_ROWS, 1'b0, 0);
      settle();
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int unsigned sent;
      sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      while (sent < RANDOM_PIXELS) begin
         if (sent < RANDOM_PIXELS / 3) begin
            send_idle_pct  = 36;
            recv_stall_pct = 72;
         end else if (sent < 2 * RANDOM_PIXELS / 3) begin
            send_idle_pct  = 72;
            recv_stall_pct = 36;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         run_random_phase(sent);
      end
      run_large_frames();
      if (tracker.outstanding() != 0)
         $display("%0d expected transfers never arrived", tracker.outstanding());
      if (tracker.mismatch_count == 0 && tracker.outstanding() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/sc3t_pkg.sv
design/sc3t_csr.sv
design/sc3t_filter.sv
design/strided_conv3x3_threshold.sv
design/sc3t_checker.sv
bench/tb_top.sv
